// ===== design/mm_pkg.sv =====
// Shared types, constants and helpers for the matrix multiplier.
// No dependencies; all files but mm_ram and mm_queue use it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package mm_pkg;

  // Element format is signed Q8.8; products and sums carry 16 fraction bits.
  localparam int ELEM_W     = 16;
  localparam int VALUE_W    = 35;
  localparam int IDX_W      = 3;
  localparam int DIM_W      = 4;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic [1:0] {
    REG_A_ROWS     = 2'd0,
    REG_INNER_SIZE = 2'd1,
    REG_B_COLS     = 2'd2
  } cfg_reg_e;

  // What the front end tells the back end about one loaded element.
  typedef enum logic [1:0] {
    CMD_A      = 2'd0,
    CMD_B      = 2'd1,
    CMD_B_LAST = 2'd2
  } cmd_kind_e;

  localparam int KIND_W = $bits(cmd_kind_e);

  typedef struct packed {
    logic [DIM_W-1:0] m;
    logic [DIM_W-1:0] n;
    logic [DIM_W-1:0] p;
  } dims_t;

  // Zero reads as one, anything above the build limit as the limit.
  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v,
                                                 logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = {{(DIM_W-1){1'b0}}, 1'b1};
    end else if (v > max_dim) begin
      r = max_dim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/mm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/mm_queue.sv =====
// Small flip-flop FIFO between the load front end and the compute back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mm_queue #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4,
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CntW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic      [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CntW'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = entry_q[rptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : PtrW'(wptr_q + 1'b1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : PtrW'(rptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/mm_front.sv =====
// Load front end: counts incoming elements, sorts them into A or B with a store
// address and flags the final one. Depends on mm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mm_front #(
  parameter int MAX_DIM = 8,
  localparam int Depth = MAX_DIM * MAX_DIM,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int CmdW  = mm_pkg::KIND_W + AddrW + mm_pkg::ELEM_W
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire mm_pkg::dims_t             dims_i,
  input  wire logic                      cfg_clear_i,
  input  wire logic                      in_valid_i,
  input  wire logic [mm_pkg::ELEM_W-1:0] in_data_i,
  output logic                           in_ready_o,
  input  wire logic                      q_full_i,
  output logic                           q_push_o,
  output logic      [CmdW-1:0]           q_data_o
);

  localparam int CntW  = (2 * Depth > 1) ? $clog2(2 * Depth) : 1;
  localparam int SizeW = CntW + 1;

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [SizeW-1:0]  size_a, total, cnt_ext, cnt_inc;
  logic              in_b, is_final, accept;
  logic [AddrW-1:0]  addr;
  mm_pkg::cmd_kind_e kind;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  always_comb begin
    size_a   = SizeW'(dims_i.m) * SizeW'(dims_i.n);
    total    = size_a + SizeW'(dims_i.n) * SizeW'(dims_i.p);
    cnt_ext  = SizeW'(cnt_q);
    cnt_inc  = cnt_ext + 1'b1;
    in_b     = (cnt_ext >= size_a);
    is_final = (cnt_inc == total);
    addr     = in_b ? AddrW'(cnt_ext - size_a) : AddrW'(cnt_ext);
    priority if (!in_b) begin
      kind = mm_pkg::CMD_A;
    end else if (is_final) begin
      kind = mm_pkg::CMD_B_LAST;
    end else begin
      kind = mm_pkg::CMD_B;
    end
    q_data_o = {kind, addr, in_data_i};

    cnt_d = cnt_q;
    if (cfg_clear_i) begin
      cnt_d = '0;
    end else if (accept) begin
      cnt_d = is_final ? '0 : CntW'(cnt_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/mm_back.sv =====
// Compute back end: drains the element queue into the A and B stores, then walks
// C row-major through one multiply-accumulate pipeline. Depends on mm_pkg, mm_ram.
`timescale 1ns / 1ps
`default_nettype none

module mm_back #(
  parameter int MAX_DIM = 8,
  localparam int Depth = MAX_DIM * MAX_DIM,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int IdxW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int CmdW  = mm_pkg::KIND_W + AddrW + mm_pkg::ELEM_W
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire mm_pkg::dims_t              dims_i,
  input  wire logic                       q_valid_i,
  input  wire logic [CmdW-1:0]            q_data_i,
  output logic                            q_pop_o,
  input  wire logic                       res_ready_i,
  output logic                            res_valid_o,
  output logic      [mm_pkg::VALUE_W-1:0] res_value_o,
  output logic      [IdxW-1:0]            res_row_o,
  output logic      [IdxW-1:0]            res_col_o,
  output logic                            res_last_o
);

  localparam int ProdW = 2 * mm_pkg::ELEM_W;

  typedef enum logic {
    ST_LOAD,
    ST_CALC
  } state_e;

  typedef struct packed {
    logic            vld;
    logic            first;
    logic            lastk;
    logic            fin;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
  } tag_t;

  state_e                       state_q;
  logic [IdxW-1:0]              i_q, j_q, k_q;
  tag_t                         tag0, t1_q, t2_q;
  logic signed [ProdW-1:0]      prod_q;
  logic signed [mm_pkg::VALUE_W-1:0] acc_q, acc_d;
  logic                         adv, issue, k_end, j_end, i_end;

  mm_pkg::cmd_kind_e            q_kind;
  logic [AddrW-1:0]             q_addr;
  logic [mm_pkg::ELEM_W-1:0]    q_elem;
  logic                         we_a, we_b;
  logic [AddrW-1:0]             raddr_a, raddr_b;
  logic [mm_pkg::ELEM_W-1:0]    rd_a, rd_b;

  assign {q_kind, q_addr, q_elem} = q_data_i;
  assign q_pop_o = q_valid_i && (state_q == ST_LOAD);

  always_comb begin
    we_a = 1'b0;
    we_b = 1'b0;
    if (q_pop_o) begin
      unique case (q_kind)
        mm_pkg::CMD_A:      we_a = 1'b1;
        mm_pkg::CMD_B,
        mm_pkg::CMD_B_LAST: we_b = 1'b1;
        default:            ;
      endcase
    end
  end

  // The whole MAC pipeline freezes while a finished result waits downstream.
  assign adv   = !res_valid_o || res_ready_i;
  assign issue = (state_q == ST_CALC) && adv;

  always_comb begin
    k_end   = (mm_pkg::DIM_W'(k_q) == dims_i.n - 1'b1);
    j_end   = (mm_pkg::DIM_W'(j_q) == dims_i.p - 1'b1);
    i_end   = (mm_pkg::DIM_W'(i_q) == dims_i.m - 1'b1);
    raddr_a = AddrW'(AddrW'(i_q) * AddrW'(dims_i.n) + AddrW'(k_q));
    raddr_b = AddrW'(AddrW'(k_q) * AddrW'(dims_i.p) + AddrW'(j_q));
    tag0.vld   = issue;
    tag0.first = (k_q == '0);
    tag0.lastk = k_end;
    tag0.fin   = i_end && j_end;
    tag0.row   = i_q;
    tag0.col   = j_q;
    acc_d = (t2_q.first ? '0 : acc_q) + mm_pkg::VALUE_W'(prod_q);
  end

  mm_ram #(.WIDTH(mm_pkg::ELEM_W), .DEPTH(Depth)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (q_addr),
    .wdata_i (q_elem),
    .re_i    (issue),
    .raddr_i (raddr_a),
    .rdata_o (rd_a)
  );

  mm_ram #(.WIDTH(mm_pkg::ELEM_W), .DEPTH(Depth)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (q_addr),
    .wdata_i (q_elem),
    .re_i    (issue),
    .raddr_i (raddr_b),
    .rdata_o (rd_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      t1_q        <= '0;
      t2_q        <= '0;
      res_valid_o <= 1'b0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (q_pop_o && (q_kind == mm_pkg::CMD_B_LAST)) begin
            state_q <= ST_CALC;
            i_q     <= '0;
            j_q     <= '0;
            k_q     <= '0;
          end
        end
        ST_CALC: begin
          if (issue) begin
            if (!k_end) begin
              k_q <= IdxW'(k_q + 1'b1);
            end else begin
              k_q <= '0;
              if (!j_end) begin
                j_q <= IdxW'(j_q + 1'b1);
              end else begin
                j_q <= '0;
                i_q <= IdxW'(i_q + 1'b1);
                if (i_end) begin
                  state_q <= ST_LOAD;
                end
              end
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase

      if (adv) begin
        t1_q <= tag0;
        t2_q <= t1_q;
        if (t2_q.vld && t2_q.lastk) begin
          res_valid_o <= 1'b1;
        end else if (res_ready_i) begin
          res_valid_o <= 1'b0;
        end
      end
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= $signed(rd_a) * $signed(rd_b);
      if (t2_q.vld) begin
        acc_q <= acc_d;
      end
      if (t2_q.vld && t2_q.lastk) begin
        res_value_o <= acc_d;
        res_row_o   <= t2_q.row;
        res_col_o   <= t2_q.col;
        res_last_o  <= t2_q.fin;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/matrix_multiply.sv =====
// Top level of the dense matrix multiplier: configuration registers, load front
// end, element queue and compute back end. Depends on mm_pkg, mm_front, mm_queue, mm_back.
//
//  Channel   Dir  Handshake                 Carries
//  s_axis    in   tvalid/tready             tdata[15:0] element (signed Q8.8)
//  m_axis    out  tvalid/tready             tdata product_value, out_row, out_col; tlast
//  apb       in   psel/penable/pwrite       a_rows @0x0, inner_size @0x4, b_cols @0x8
//
// Elements load at one per cycle until the queue fills. After the final B element
// reaches the back end, C is computed in row-major order through the single
// multiply-accumulate unit, which reads each store through its one read port.
// Reset clears the load count and control; the A and B stores are not cleared.
// A stalled m_axis freezes the MAC pipeline; the queue then fills and s_axis stalls.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply #(
  parameter int MAX_DIM = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // tdata: element[15:0]
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [mm_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // tdata: product_value[34:0], out_row[37:35], out_col[40:38], zero pad[47:41]
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic      [mm_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                               m_axis_tlast_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mm_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [mm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [mm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                               pready
);

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int IdxW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CmdW  = mm_pkg::KIND_W + AddrW + mm_pkg::ELEM_W;
  localparam int PadW  = mm_pkg::OUT_DATA_W - mm_pkg::VALUE_W - 2 * mm_pkg::IDX_W;

  logic [mm_pkg::DIM_W-1:0] a_rows_q, inner_size_q, b_cols_q;
  logic                     cfg_wr, cfg_clear;
  mm_pkg::cfg_reg_e         cfg_sel;
  mm_pkg::dims_t            dims;

  logic                     q_push, q_full, q_pop, q_valid;
  logic [CmdW-1:0]          q_wdata, q_rdata;

  logic [mm_pkg::VALUE_W-1:0] res_value;
  logic [IdxW-1:0]            res_row, res_col;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = mm_pkg::cfg_reg_e'(paddr[3:2]);

  always_comb begin
    cfg_clear = 1'b0;
    prdata    = '0;
    unique case (cfg_sel)
      mm_pkg::REG_A_ROWS: begin
        cfg_clear = cfg_wr;
        prdata    = mm_pkg::CFG_DATA_W'(a_rows_q);
      end
      mm_pkg::REG_INNER_SIZE: begin
        cfg_clear = cfg_wr;
        prdata    = mm_pkg::CFG_DATA_W'(inner_size_q);
      end
      mm_pkg::REG_B_COLS: begin
        cfg_clear = cfg_wr;
        prdata    = mm_pkg::CFG_DATA_W'(b_cols_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q     <= mm_pkg::DIM_RESET;
      inner_size_q <= mm_pkg::DIM_RESET;
      b_cols_q     <= mm_pkg::DIM_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        mm_pkg::REG_A_ROWS:     a_rows_q     <= pwdata[mm_pkg::DIM_W-1:0];
        mm_pkg::REG_INNER_SIZE: inner_size_q <= pwdata[mm_pkg::DIM_W-1:0];
        mm_pkg::REG_B_COLS:     b_cols_q     <= pwdata[mm_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    dims.m = mm_pkg::clamp_dim(a_rows_q, mm_pkg::DIM_W'(MAX_DIM));
    dims.n = mm_pkg::clamp_dim(inner_size_q, mm_pkg::DIM_W'(MAX_DIM));
    dims.p = mm_pkg::clamp_dim(b_cols_q, mm_pkg::DIM_W'(MAX_DIM));
  end

  mm_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dims_i      (dims),
    .cfg_clear_i (cfg_clear),
    .in_valid_i  (s_axis_tvalid_i),
    .in_data_i   (s_axis_tdata_i[mm_pkg::ELEM_W-1:0]),
    .in_ready_o  (s_axis_tready_o),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  mm_queue #(.WIDTH(CmdW), .DEPTH(mm_pkg::QUEUE_DEPTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rdata)
  );

  mm_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dims_i      (dims),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .res_ready_i (m_axis_tready_i),
    .res_valid_o (m_axis_tvalid_o),
    .res_value_o (res_value),
    .res_row_o   (res_row),
    .res_col_o   (res_col),
    .res_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{PadW{1'b0}},
                           mm_pkg::IDX_W'(res_col),
                           mm_pkg::IDX_W'(res_row),
                           res_value};

endmodule

`default_nettype wire

// ===== design/mm_checker.sv =====
// Port-level checks on the result stream of matrix_multiply, bound to the top.
// Depends on mm_pkg and matrix_multiply.
`timescale 1ns / 1ps
`default_nettype none

module mm_port_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          m_axis_tvalid_o,
  input wire logic                          m_axis_tready_i,
  input wire logic [mm_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input wire logic                          m_axis_tlast_o
);

  localparam int RowLo = mm_pkg::VALUE_W;
  localparam int ColLo = mm_pkg::VALUE_W + mm_pkg::IDX_W;
  localparam int PadLo = mm_pkg::VALUE_W + 2 * mm_pkg::IDX_W;

  logic [mm_pkg::IDX_W-1:0] row, col, prev_row_q, prev_col_q;
  logic                     taken, mid_q;

  assign row   = m_axis_tdata_o[ColLo-1:RowLo];
  assign col   = m_axis_tdata_o[PadLo-1:ColLo];
  assign taken = m_axis_tvalid_o && m_axis_tready_i;

  // Tracks whether a result matrix is partly delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q      <= 1'b0;
      prev_row_q <= '0;
      prev_col_q <= '0;
    end else if (taken) begin
      mid_q      <= !m_axis_tlast_o;
      prev_row_q <= row;
      prev_col_q <= col;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[mm_pkg::OUT_DATA_W-1:PadLo] == '0))
    else $error("result pad bits not zero");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    taken && !mid_q |-> (row == '0) && (col == '0))
    else $error("result matrix does not start at row 0, column 0");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    taken && mid_q |->
      ((row == prev_row_q) && (col == mm_pkg::IDX_W'(prev_col_q + 1'b1))) ||
      ((row == mm_pkg::IDX_W'(prev_row_q + 1'b1)) && (col == '0)))
    else $error("result elements out of row-major order");

endmodule

bind matrix_multiply mm_port_checker u_mm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire
